// ===== rtl/core/sensor_range_filter_moving_average_macros.svh =====
// assertion macros for the sensor range filter checker
// needs clk and rst_n in the scope where a macro is used
`ifndef SENSOR_RANGE_FILTER_MOVING_AVERAGE_MACROS_SVH
`define SENSOR_RANGE_FILTER_MOVING_AVERAGE_MACROS_SVH

// checked outside reset only
`define SRFMA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define SRFMA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/srfma_pkg.sv =====
// shared types and constants for the sensor range filter moving average
// no dependencies
package srfma_pkg;

  localparam int SAMPLE_BITS     = 12;
  localparam int WINDOW          = 8;
  localparam int WIN_BITS        = $clog2(WINDOW);
  localparam int SUM_W           = SAMPLE_BITS + WIN_BITS;
  localparam int IDX_W           = 6;
  localparam int GAIN_W          = 16;
  localparam int OUT_W           = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int BATCH_LIMIT_DEF = 64;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_RAW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RAW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q16     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Q8    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_LIMIT = 3'd4;

  localparam logic [SAMPLE_BITS-1:0]  MIN_RAW_RST      = 12'd200;
  localparam logic [SAMPLE_BITS-1:0]  MAX_RAW_RST      = 12'd3800;
  localparam logic [GAIN_W-1:0]       GAIN_Q16_RST     = 16'd1600;
  localparam logic signed [OUT_W-1:0] OFFSET_Q8_RST    = -16'sd2560;
  localparam logic [IDX_W-1:0]        RESULT_LIMIT_RST = 6'd57;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] raw_sample;
    logic                   new_batch;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] average;
    logic [IDX_W-1:0]        window_index;
  } out_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]  min_raw;
    logic [SAMPLE_BITS-1:0]  max_raw;
    logic [GAIN_W-1:0]       gain_q16;
    logic signed [OUT_W-1:0] offset_q8;
    logic [IDX_W-1:0]        result_limit;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    logic [IDX_W-1:0] index;
  } stage_t;

endpackage

// ===== rtl/core/srfma_window.sv =====
// range gate, delay line with running sum and batch counters
// depends on srfma_pkg
module srfma_window
  import srfma_pkg::*;
#(
  parameter int BATCH_LIMIT = BATCH_LIMIT_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   accept,
  input  logic   adv,
  input  in_t    in_data,
  input  cfg_t   cfg,
  output stage_t s1
);

  localparam int ACC_W = $clog2(BATCH_LIMIT + 1);

  logic [SAMPLE_BITS-1:0] store_r [WINDOW];
  logic [SUM_W-1:0]       sum_r, sum_eff, sum_nxt;
  logic [ACC_W-1:0]       acc_r, acc_eff, acc_nxt;
  logic [IDX_W-1:0]       emit_r, emit_eff, emit_nxt;
  logic [SAMPLE_BITS-1:0] old_smp;
  logic [WIN_BITS-1:0]    slot;
  logic                   clr, gate_ok, room, take, fire;
  stage_t                 s1_r;

  always_comb begin
    clr      = in_data.new_batch;
    sum_eff  = clr ? '0 : sum_r;
    acc_eff  = clr ? '0 : acc_r;
    emit_eff = clr ? '0 : emit_r;
    slot     = acc_eff[WIN_BITS-1:0];
    old_smp  = clr ? '0 : store_r[slot];
    gate_ok  = (in_data.raw_sample >= cfg.min_raw) && (in_data.raw_sample <= cfg.max_raw);
    room     = acc_eff < ACC_W'(BATCH_LIMIT);
    take     = accept && gate_ok && room;
    sum_nxt  = sum_eff - SUM_W'(old_smp) + SUM_W'(in_data.raw_sample);
    acc_nxt  = acc_eff + 1'b1;
    emit_nxt = emit_eff + 1'b1;
    fire     = take && (acc_nxt >= ACC_W'(WINDOW)) && (emit_eff < cfg.result_limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) store_r[i] <= '0;
      sum_r  <= '0;
      acc_r  <= '0;
      emit_r <= '0;
    end else if (accept) begin
      for (int i = 0; i < WINDOW; i++) begin
        if (take && (slot == WIN_BITS'(i))) begin
          store_r[i] <= in_data.raw_sample;
        end else if (clr) begin
          store_r[i] <= '0;
        end
      end
      sum_r  <= take ? sum_nxt : sum_eff;
      acc_r  <= take ? acc_nxt : acc_eff;
      emit_r <= fire ? emit_nxt : emit_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (adv) begin
      s1_r.valid <= fire;
    end
    if (adv) begin
      s1_r.sum   <= sum_nxt;
      s1_r.index <= emit_eff;
    end
  end

  assign s1 = s1_r;

endmodule

// ===== rtl/core/srfma_calib.sv =====
// calibration: gain multiply, rounding, offset and saturation, two stages
// depends on srfma_pkg
module srfma_calib
  import srfma_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  stage_t                  s1,
  input  logic [GAIN_W-1:0]       gain_q16,
  input  logic signed [OUT_W-1:0] offset_q8,
  output logic                    out_valid,
  output out_t                    out_data
);

  localparam int PROD_W    = SUM_W + GAIN_W;
  localparam int DIV_SHIFT = 8 + WIN_BITS;
  localparam int Q_W       = PROD_W + 1 - DIV_SHIFT;
  localparam int V_W       = Q_W + 2;
  localparam logic [PROD_W:0] RND_HALF = (PROD_W + 1)'(1) << (DIV_SHIFT - 1);
  localparam logic signed [V_W-1:0] SAT_HI = V_W'((2 ** (OUT_W - 1)) - 1);
  localparam logic signed [V_W-1:0] SAT_LO = -V_W'(2 ** (OUT_W - 1));

  logic                    v2_r;
  logic [PROD_W-1:0]       prod_r;
  logic [IDX_W-1:0]        idx2_r;
  logic [PROD_W:0]         rnd;
  logic [Q_W-1:0]          q;
  logic signed [V_W-1:0]   v;
  logic signed [OUT_W-1:0] sat;
  logic                    out_valid_r;
  out_t                    out_data_r;

  always_comb begin
    rnd = {1'b0, prod_r} + RND_HALF;
    q   = rnd[PROD_W:DIV_SHIFT];
    v   = signed'(V_W'(q)) + V_W'(offset_q8);
    if (v > SAT_HI) begin
      sat = SAT_HI[OUT_W-1:0];
    end else if (v < SAT_LO) begin
      sat = SAT_LO[OUT_W-1:0];
    end else begin
      sat = v[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v2_r        <= s1.valid;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r                  <= PROD_W'(s1.sum) * PROD_W'(gain_q16);
      idx2_r                  <= s1.index;
      out_data_r.average      <= sat;
      out_data_r.window_index <= idx2_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/sensor_range_filter_moving_average.sv =====
// top level: range-gated moving average with linear calibration
// depends on srfma_pkg, srfma_window, srfma_calib
//
//  channel | ports                        | moves
//  in      | in_valid in_ready in_data    | raw sample request, new batch flag
//  out     | out_valid out_ready out_data | calibrated window mean and index
//  cfg     | cfg_we cfg_index cfg_wdata   | register write, no wait
//
// one request per cycle while no result waits at out_data; results are registered
// after the window update, the gain multiply and the round/saturate stages
// the whole pipeline holds while a result waits at out_data
// synchronous active-low reset restores register defaults and clears the window
module sensor_range_filter_moving_average
  import srfma_pkg::*;
#(
  parameter int BATCH_LIMIT = BATCH_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t   cfg_r;
  stage_t s1;
  logic   adv, accept;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_raw      <= MIN_RAW_RST;
      cfg_r.max_raw      <= MAX_RAW_RST;
      cfg_r.gain_q16     <= GAIN_Q16_RST;
      cfg_r.offset_q8    <= OFFSET_Q8_RST;
      cfg_r.result_limit <= RESULT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_RAW:      cfg_r.min_raw      <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_MAX_RAW:      cfg_r.max_raw      <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_GAIN_Q16:     cfg_r.gain_q16     <= cfg_wdata[GAIN_W-1:0];
        REG_OFFSET_Q8:    cfg_r.offset_q8    <= signed'(cfg_wdata[OUT_W-1:0]);
        REG_RESULT_LIMIT: cfg_r.result_limit <= cfg_wdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  srfma_window #(
    .BATCH_LIMIT(BATCH_LIMIT)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .adv     (adv),
    .in_data (in_data),
    .cfg     (cfg_r),
    .s1      (s1)
  );

  srfma_calib u_calib (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s1        (s1),
    .gain_q16  (cfg_r.gain_q16),
    .offset_q8 (cfg_r.offset_q8),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/srfma_checker.sv =====
// port-level checks for the sensor range filter, bound to the top level
// depends on srfma_pkg and the assertion macro header
`include "sensor_range_filter_moving_average_macros.svh"

module srfma_checker
  import srfma_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  `SRFMA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `SRFMA_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_data), "result changed while stalled")
  `SRFMA_ASSERT(a_stall_blocks_in, out_valid && !out_ready |-> !in_ready, "request taken while output stalled")
  `SRFMA_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind sensor_range_filter_moving_average srfma_checker u_srfma_checker (.*);
